// ===== hw/rtl/rle_atd_pkg.sv =====
`default_nettype none

package rle_atd_pkg;

    // Track layout
    localparam int CHANNELS     = 7;
    localparam int ROT_CHANNELS = 4;
    localparam logic [3:0] ROT_PRECISION = 4'd15;

    // Header byte fields
    localparam logic [7:0] HDR_RUN_MASK   = 8'b1000_0000;
    localparam logic [7:0] HDR_COUNT_MASK = 8'b0111_1111;

    // Frame position saturates here
    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    // Register indexes on the configuration channel
    localparam logic REG_FRAME_COUNT   = 1'b0;
    localparam logic REG_POS_PRECISION = 1'b1;

    // Rounding thresholds for a remainder sum over 32767 (no ties, divisor is odd)
    localparam logic [15:0] ROUND_ONE = 16'd16384;
    localparam logic [15:0] ROUND_TWO = 16'd49151;

    typedef enum logic [2:0] {
        PH_LEN_LO = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_BUD_LO = 3'd2,
        PH_BUD_HI = 3'd3,
        PH_HEADER = 3'd4,
        PH_SKIP   = 3'd5,
        PH_VAL_LO = 3'd6,
        PH_VAL_HI = 3'd7
    } phase_t;

    function automatic logic budget_positive(input logic [15:0] bud);
        return (bud != 16'd0) && !bud[15];
    endfunction

    // round(v * 2^(32-p) / 32767) without a divider.
    // With s = 32-p = 15*t + j, 2^15 == 1 (mod 32767) gives
    // X/32767 = m*Q_t + m/32767, m = |v|*2^j, Q_1 = 1, Q_2 = 2^15+1,
    // and m/32767 = h + (h+l)/32767 where m = h*2^15 + l.
    function automatic logic [33:0] scale_sample(input logic [15:0] raw,
                                                 input logic [3:0]  prec);
        logic        neg;
        logic [16:0] mag17;
        logic [15:0] mag;
        logic [5:0]  s;
        logic [3:0]  j;
        logic        t2;
        logic [29:0] m;
        logic [14:0] h;
        logic [14:0] l;
        logic [15:0] r;
        logic [1:0]  q2;
        logic [33:0] base;
        logic [33:0] q;
        neg   = raw[15];
        mag17 = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        mag   = mag17[15:0];
        s     = 6'd32 - {2'b00, prec};
        if (s >= 6'd30) begin
            j  = 4'(s - 6'd30);
            t2 = 1'b1;
        end else begin
            j  = 4'(s - 6'd15);
            t2 = 1'b0;
        end
        m  = {14'd0, mag} << j;
        h  = m[29:15];
        l  = m[14:0];
        r  = {1'b0, h} + {1'b0, l};
        q2 = (r >= ROUND_TWO) ? 2'd2 : ((r >= ROUND_ONE) ? 2'd1 : 2'd0);
        base = t2 ? (({4'd0, m} << 15) + {4'd0, m}) : {4'd0, m};
        q    = base + {19'd0, h} + {32'd0, q2};
        return neg ? (34'd0 - q) : q;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rle_animation_track_decoder_unit.sv =====
// Run-length animation track decoder.
// Input: one track byte per beat on s_tdata (s_tvalid/s_tready). The byte
// stream is a 2-byte total length, then per channel a signed 16-bit budget
// and chunks (header, skip byte, one shared sample or one sample per frame).
// Output: exactly one beat per input byte on m_*. m_tuser[0] marks a run to
// write (channel, start frame, length, Q16 value in m_tdata), m_tuser[1] a
// run dropped for passing frame_count, m_tlast the byte that ends a track.
// Configuration: cfg_index 0 = frame_count, 1 = position_precision; write
// only while no byte is in flight.
// The result beat of a byte is loaded into the output register by the edge that accepts it.
// Throughput: one byte per cycle while the receiver takes each beat; the parser state
// and the output register both update in the accepting cycle, and s_tready follows the
// output register (ready when it is empty or being taken).
// Reset (aresetn low at a clock edge): parser back to the total length low
// byte, output register empty, frame_count = 1, position_precision = 15.
// When the receiver stalls, the result beat holds and s_tready drops until
// it is taken; no byte is lost.

`default_nettype none

module rle_animation_track_decoder_unit
    import rle_atd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [2:0] channel, [18:3] start_frame,
                                        // [25:19] run_length, [59:26] scaled_value,
                                        // [63:60] zero
    output logic [1:0]       m_tuser,   // [0] run_valid, [1] frame_overflow
    output logic             m_tlast,   // track_done

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Configuration registers
    logic [15:0] frame_count_reg;
    logic [3:0]  precision_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [2:0]  channel_reg, channel_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] budget_reg, budget_next;
    logic        run_flag_reg, run_flag_next;
    logic [6:0]  cfl_reg, cfl_next;
    logic [7:0]  skip_reg, skip_next;
    logic [7:0]  low_reg, low_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        res_valid_reg, res_valid;
    logic        res_ovf_reg, res_ovf;
    logic        res_done_reg, res_done;
    logic [2:0]  res_ch_reg, res_ch;
    logic [15:0] res_start_reg, res_start;
    logic [6:0]  res_len_reg, res_len;
    logic [33:0] res_val_reg, res_val;

    // Step helpers
    logic        s_fire;
    logic        do_end;
    logic        do_next;
    logic [7:0]  skip_src;
    logic [15:0] bud_new;
    logic [15:0] bud_sub;
    logic [15:0] raw;
    logic [3:0]  prec;
    logic [33:0] scaled;
    logic [6:0]  n;
    logic [17:0] pos_sum;
    logic [6:0]  cfl_dec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_val_reg, res_len_reg, res_start_reg, res_ch_reg};
    assign m_tuser  = {res_ovf_reg, res_valid_reg};
    assign m_tlast  = res_done_reg;

    // Sample path: scale the 16-bit sample formed by this byte and the held low byte
    assign raw     = {s_tdata, low_reg};
    assign prec    = (channel_reg < 3'(ROT_CHANNELS)) ? ROT_PRECISION : precision_reg;
    assign scaled  = scale_sample(raw, prec);
    assign n       = run_flag_reg ? cfl_reg : 7'd1;
    assign pos_sum = {1'b0, pos_reg} + {11'd0, n};
    assign cfl_dec = cfl_reg - 7'd1;
    assign bud_new = {s_tdata, low_reg};
    assign bud_sub = budget_reg - {{8{skip_src[7]}}, skip_src};

    // Next state and result for one byte
    always_comb begin
        phase_next    = phase_reg;
        channel_next  = channel_reg;
        pos_next      = pos_reg;
        budget_next   = budget_reg;
        run_flag_next = run_flag_reg;
        cfl_next      = cfl_reg;
        skip_next     = skip_reg;
        low_next      = low_reg;
        do_end        = 1'b0;
        do_next       = 1'b0;
        skip_src      = skip_reg;
        res_valid     = 1'b0;
        res_ovf       = 1'b0;
        res_done      = 1'b0;
        res_ch        = 3'd0;
        res_start     = 16'd0;
        res_len       = 7'd0;
        res_val       = 34'd0;

        unique case (phase_reg)
            PH_LEN_LO: begin
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                phase_next = PH_BUD_LO;
            end
            PH_BUD_LO: begin
                low_next   = s_tdata;
                phase_next = PH_BUD_HI;
            end
            PH_BUD_HI: begin
                budget_next = bud_new;
                pos_next    = 17'd0;
                if (budget_positive(bud_new)) begin
                    phase_next = PH_HEADER;
                end else begin
                    do_next = 1'b1;
                end
            end
            PH_HEADER: begin
                run_flag_next = |(s_tdata & HDR_RUN_MASK);
                cfl_next      = 7'(s_tdata & HDR_COUNT_MASK);
                phase_next    = PH_SKIP;
            end
            PH_SKIP: begin
                skip_next = s_tdata;
                if (!run_flag_reg && (cfl_reg == 7'd0)) begin
                    skip_src = s_tdata;
                    do_end   = 1'b1;
                end else begin
                    phase_next = PH_VAL_LO;
                end
            end
            PH_VAL_LO: begin
                low_next   = s_tdata;
                phase_next = PH_VAL_HI;
            end
            PH_VAL_HI: begin
                if (n != 7'd0) begin
                    res_ch    = channel_reg;
                    res_start = pos_reg[15:0];
                    res_len   = n;
                    res_val   = scaled;
                    if (pos_sum > {2'b00, frame_count_reg}) begin
                        res_ovf = 1'b1;
                    end else begin
                        res_valid = 1'b1;
                    end
                    pos_next = pos_sum[17] ? POS_MAX : pos_sum[16:0];
                end
                if (run_flag_reg) begin
                    do_end = 1'b1;
                end else begin
                    cfl_next = cfl_dec;
                    if (cfl_dec == 7'd0) begin
                        do_end = 1'b1;
                    end else begin
                        phase_next = PH_VAL_LO;
                    end
                end
            end
        endcase

        // End of chunk: charge the skip byte to the budget
        if (do_end) begin
            budget_next = bud_sub;
            if (budget_positive(bud_sub)) begin
                phase_next = PH_HEADER;
            end else begin
                do_next = 1'b1;
            end
        end

        // End of channel: advance, or wrap to the next track
        if (do_next) begin
            pos_next = 17'd0;
            if (channel_reg >= 3'(CHANNELS - 1)) begin
                channel_next = 3'd0;
                phase_next   = PH_LEN_LO;
                res_done     = 1'b1;
            end else begin
                channel_next = channel_reg + 3'd1;
                phase_next   = PH_BUD_LO;
            end
        end
    end

    // Output register: load on each accepted beat, drop when taken
    always_comb begin
        if (s_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and parser registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_LEN_LO;
            channel_reg     <= 3'd0;
            pos_reg         <= 17'd0;
            budget_reg      <= 16'd0;
            run_flag_reg    <= 1'b0;
            cfl_reg         <= 7'd0;
            skip_reg        <= 8'd0;
            low_reg         <= 8'd0;
            out_valid_reg   <= 1'b0;
            frame_count_reg <= 16'd1;
            precision_reg   <= 4'd15;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_fire) begin
                phase_reg    <= phase_next;
                channel_reg  <= channel_next;
                pos_reg      <= pos_next;
                budget_reg   <= budget_next;
                run_flag_reg <= run_flag_next;
                cfl_reg      <= cfl_next;
                skip_reg     <= skip_next;
                low_reg      <= low_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_COUNT:   frame_count_reg <= cfg_data;
                    REG_POS_PRECISION: precision_reg   <= cfg_data[3:0];
                    default:           ;
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_valid_reg <= res_valid;
            res_ovf_reg   <= res_ovf;
            res_done_reg  <= res_done;
            res_ch_reg    <= res_ch;
            res_start_reg <= res_start;
            res_len_reg   <= res_len;
            res_val_reg   <= res_val;
        end
    end

`ifndef ASSERT_OFF
    // Every accepted byte leaves a result beat
    a_beat_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid)
        else $error("accepted byte produced no result beat");

    // A run, written or dropped, never has zero length
    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> (m_tdata[25:19] != 7'd0))
        else $error("run with zero length");

    // A run is either written or dropped, not both
    a_run_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("run both written and dropped");

    // Channel index stays within the track
    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        channel_reg <= 3'(CHANNELS - 1))
        else $error("channel index out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/rle_animation_track_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module rle_animation_track_decoder_unit_tb;
    import rle_atd_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] stream_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [2:0] channel, [18:3] start_frame, [25:19] run_length,
                            // [59:26] scaled_value, [63:60] zero
    logic [1:0]  m_tuser;   // [0] run_valid, [1] frame_overflow
    logic        m_tlast;   // track_done
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    typedef struct packed {
        logic        run_valid;
        logic [2:0]  channel;
        logic [15:0] start_frame;
        logic [6:0]  run_length;
        logic [33:0] scaled_value;
        logic        track_done;
        logic        frame_overflow;
    } track_beat_t;

    // Expected output beats, oldest first
    track_beat_t expected_beats[$];
    int          err_cnt = 0;

    // Track parser state mirrored on the testbench side
    phase_t      trk_phase;
    logic [2:0]  trk_chan;
    logic [16:0] trk_pos;
    logic [15:0] trk_budget;
    logic        trk_run;
    logic [6:0]  trk_left;
    logic [7:0]  trk_skip;
    logic [7:0]  trk_lo;
    logic [15:0] fc_reg;
    logic [3:0]  prec_reg;

    // Stimulus shaping
    logic [15:0] plan_budget;
    logic        src_gaps = 1'b1;
    logic        dst_gaps = 1'b1;
    int          src_cnt = 0;
    int          dst_cnt = 0;

    rle_animation_track_decoder_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Signed Q16 scaling: round(v * 2^(32-p) / 32767); the divisor is odd, so no ties
    function automatic logic [33:0] q16_of(input logic [15:0] raw, input logic [3:0] p);
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] quo;
        mag = raw[15] ? 64'(17'h10000 - {1'b0, raw}) : 64'(raw);
        num = mag << (32 - p);
        quo = (num + 64'd16383) / 64'd32767;
        return raw[15] ? 34'(64'd0 - quo) : quo[33:0];
    endfunction

    // Leave the current channel; high when the track is complete
    function automatic logic close_channel();
        trk_pos = '0;
        if (trk_chan >= CHANNELS - 1) begin
            trk_chan  = '0;
            trk_phase = PH_LEN_LO;
            return 1'b1;
        end
        trk_chan  = trk_chan + 3'd1;
        trk_phase = PH_BUD_LO;
        return 1'b0;
    endfunction

    // Charge the signed skip byte against the budget, then continue or leave the channel
    function automatic logic close_chunk();
        trk_budget = trk_budget - {{8{trk_skip[7]}}, trk_skip};
        if (trk_budget != 16'd0 && !trk_budget[15]) begin
            trk_phase = PH_HEADER;
            return 1'b0;
        end
        return close_channel();
    endfunction

    // Advance the mirrored parser by one accepted byte and form the expected beat
    task automatic decode_byte(input logic [7:0] b, output track_beat_t r);
        logic [15:0] raw;
        logic [7:0]  n;
        logic [17:0] sum;
        logic [3:0]  p;
        logic        last;
        r = '0;
        case (trk_phase)
            PH_LEN_LO: trk_phase = PH_LEN_HI;
            PH_LEN_HI: trk_phase = PH_BUD_LO;
            PH_BUD_LO: begin
                trk_lo    = b;
                trk_phase = PH_BUD_HI;
            end
            PH_BUD_HI: begin
                trk_budget = {b, trk_lo};
                trk_pos    = '0;
                if (trk_budget != 16'd0 && !trk_budget[15])
                    trk_phase = PH_HEADER;
                else
                    r.track_done = close_channel();
            end
            PH_HEADER: begin
                trk_run   = (b & HDR_RUN_MASK) != 8'd0;
                trk_left  = 7'(b & HDR_COUNT_MASK);
                trk_phase = PH_SKIP;
            end
            PH_SKIP: begin
                trk_skip = b;
                if (!trk_run && trk_left == 7'd0)
                    r.track_done = close_chunk();
                else
                    trk_phase = PH_VAL_LO;
            end
            PH_VAL_LO: begin
                trk_lo    = b;
                trk_phase = PH_VAL_HI;
            end
            default: begin
                raw = {b, trk_lo};
                n   = trk_run ? {1'b0, trk_left} : 8'd1;
                p   = (trk_chan < ROT_CHANNELS) ? ROT_PRECISION : prec_reg;
                if (n != 8'd0) begin
                    r.channel      = trk_chan;
                    r.start_frame  = trk_pos[15:0];
                    r.run_length   = n[6:0];
                    r.scaled_value = q16_of(raw, p);
                    sum = {1'b0, trk_pos} + {10'd0, n};
                    if (sum > {2'b00, fc_reg})
                        r.frame_overflow = 1'b1;
                    else
                        r.run_valid = 1'b1;
                    trk_pos = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[16:0];
                end
                if (trk_run) begin
                    last = 1'b1;
                end else begin
                    trk_left = trk_left - 7'd1;
                    last     = (trk_left == 7'd0);
                end
                if (last)
                    r.track_done = close_chunk();
                else
                    trk_phase = PH_VAL_LO;
            end
        endcase
    endtask

    // Choose a byte that fits the parser's current phase, with a little noise
    task automatic next_track_byte(output logic [7:0] b);
        int r;
        r = $urandom_range(0, 99);
        b = 8'($urandom);
        if (r >= 3) begin
            case (trk_phase)
                PH_BUD_LO: begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        plan_budget = 16'd0;
                    else if (r < 18)
                        plan_budget = {1'b1, 15'($urandom)};
                    else if (r < 30)
                        plan_budget = 16'($urandom_range(13, 255));
                    else
                        plan_budget = 16'($urandom_range(1, 12));
                    b = plan_budget[7:0];
                end
                PH_BUD_HI: b = plan_budget[15:8];
                PH_HEADER: begin
                    r = $urandom_range(0, 99);
                    b[7] = 1'($urandom_range(0, 1));
                    if (r < 6)
                        b[6:0] = 7'd0;
                    else if (r < 16)
                        b[6:0] = 7'($urandom_range(100, 127));
                    else
                        b[6:0] = 7'($urandom_range(1, 8));
                end
                PH_SKIP: begin
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        b = 8'($urandom_range(1, 4));
                    else if (r < 84)
                        b = 8'h00;
                    else if (r < 88)
                        b = 8'($urandom_range(8'hFC, 8'hFF));
                    else if (r < 89)
                        b = 8'h80;
                    else
                        b = 8'($urandom_range(5, 127));
                end
                PH_VAL_LO: begin
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        b = r[0] ? 8'hFF : 8'h00;
                end
                PH_VAL_HI: begin
                    r = $urandom_range(0, 99);
                    if (r < 20) begin
                        case (r % 4)
                            0: b = 8'h00;
                            1: b = 8'h7F;
                            2: b = 8'h80;
                            default: b = 8'hFF;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    endtask

    // Offer one byte, hold it until taken, and queue the beat it must produce
    task automatic send_byte(input logic [7:0] b);
        int          gap;
        logic        took;
        track_beat_t w;
        if (src_cnt % 64 == 0)
            src_gaps = ($urandom_range(0, 3) != 0);
        src_cnt++;
        gap = src_gaps ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        // Sample ready ahead of the edge that may take the beat
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        decode_byte(b, w);
        expected_beats.push_back(w);
    endtask

    // Drop valid and wait until every queued beat has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_beats.size() != 0);
    endtask

    // Write frame_count, then position_precision (upper data bits are don't-care)
    task automatic write_config(input logic [15:0] frames, input logic [15:0] prec_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_COUNT;
        cfg_data  <= frames;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        fc_reg = frames;
        cfg_index <= REG_POS_PRECISION;
        cfg_data  <= prec_word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        prec_reg = prec_word[3:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string nm, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= 50)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
        end
    endtask

    task automatic check_beat();
        track_beat_t w;
        if (expected_beats.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 50)
                $display("%0t: unexpected output beat, expected none, actual tdata %0h tuser %0h",
                         $time, m_tdata, m_tuser);
            return;
        end
        w = expected_beats.pop_front();
        check_field("run_valid", 64'(w.run_valid), 64'(m_tuser[0]));
        check_field("frame_overflow", 64'(w.frame_overflow), 64'(m_tuser[1]));
        check_field("track_done", 64'(w.track_done), 64'(m_tlast));
        check_field("channel", 64'(w.channel), 64'(m_tdata[2:0]));
        check_field("start_frame", 64'(w.start_frame), 64'(m_tdata[18:3]));
        check_field("run_length", 64'(w.run_length), 64'(m_tdata[25:19]));
        check_field("scaled_value", 64'(w.scaled_value), 64'(m_tdata[59:26]));
        check_field("tdata pad", 64'd0, 64'(m_tdata[63:60]));
    endtask

    // Output side: stall at random, check each beat just ahead of the edge that takes it
    initial begin
        int   stall;
        logic took;
        wait (aresetn === 1'b1);
        forever begin
            if (dst_cnt % 64 == 0)
                dst_gaps = ($urandom_range(0, 3) != 0);
            dst_cnt++;
            stall = dst_gaps ? $urandom_range(0, 18) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                took = m_tvalid;
                if (took)
                    check_beat();
                @(posedge aclk);
            end while (!took);
        end
    end

    // One short track under reset settings: max budget with wrapping skip, negative and
    // zero budgets, empty per-frame chunk, zero-length run chunk, value extremes,
    // an overflowing run, and the end of the track
    task automatic test_reset_values();
        send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'h7F);
        send_byte(8'h81); send_byte(8'h80); send_byte(8'h00); send_byte(8'h80);
        send_byte(8'h00); send_byte(8'h80);
        send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h03); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h01);
        send_byte(8'h80); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h7F);
        send_byte(8'h02); send_byte(8'h02); send_byte(8'hFF); send_byte(8'h7F);
        send_byte(8'h01); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00);
    endtask

    // Mostly well-formed tracks with random content under one setting
    task automatic test_random_tracks(input logic [15:0] frames, input logic [15:0] prec_word,
                                      input int n_bytes);
        logic [7:0] b;
        wait_idle();
        write_config(frames, prec_word);
        repeat (n_bytes) begin
            next_track_byte(b);
            send_byte(b);
        end
    endtask

    // One channel of many full-length runs, driving the frame position far up
    task automatic test_long_channel();
        logic [7:0] b;
        wait_idle();
        write_config(16'hFFFF, 16'($urandom));
        while (trk_phase != PH_LEN_LO) begin
            next_track_byte(b);
            send_byte(b);
        end
        send_byte(8'($urandom)); send_byte(8'($urandom));
        send_byte(8'hFF); send_byte(8'h7F);
        repeat (100) begin
            send_byte(8'hFF);
            send_byte(8'h00);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end
        // empty chunk with skip -1 pushes the budget to negative
        send_byte(8'h00); send_byte(8'hFF);
        repeat (12) send_byte(8'h00);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FRAME_COUNT;
        cfg_data  <= 16'd0;
        trk_phase  = PH_LEN_LO;
        trk_chan   = '0;
        trk_pos    = '0;
        trk_budget = '0;
        trk_run    = 1'b0;
        trk_left   = '0;
        trk_skip   = '0;
        trk_lo     = '0;
        fc_reg     = 16'd1;
        prec_reg   = ROT_PRECISION;
        plan_budget = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_random_tracks(16'hFFFF, 16'h0000, 150);
        test_random_tracks(16'd1, 16'hFFFF, 150);
        test_random_tracks(16'($urandom_range(1, 300)), 16'($urandom), 150);
        test_random_tracks(16'd40, 16'h0008, 150);
        test_random_tracks(16'($urandom_range(1, 300)), 16'($urandom), 150);
        test_random_tracks(16'($urandom_range(1, 300)), 16'($urandom), 150);
        test_long_channel();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (err_cnt == 0)
            $display("rle_animation_track_decoder_unit_tb OK");
        else
            $display("rle_animation_track_decoder_unit_tb NOT OK");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2000000;
        $display("rle_animation_track_decoder_unit_tb NOT OK");
        $finish;
    end

endmodule
